[rtl/lpht_pkg.sv]
package lpht_pkg;

    // Table geometry and field widths
    localparam int SLOTS_DEF = 1024;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int LIVE_W    = 11;
    localparam int FILL_W    = 11;

    localparam logic [FILL_W-1:0] FILL_LIMIT_RST = 11'd768;

    // Request operations
    typedef enum logic [2:0] {
        OP_GET     = 3'd0,
        OP_PUT     = 3'd1,
        OP_REPLACE = 3'd2,
        OP_ADD     = 3'd3,
        OP_REMOVE  = 3'd4
    } op_t;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } state_t;

    // Bucket write command (address travels separately, its width is per instance)
    typedef struct packed {
        logic             key_we;
        logic             val_we;
        logic             live;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } mem_wr_t;

endpackage

[rtl/lpht_req_if.sv]
interface lpht_req_if;
    import lpht_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic [KEY_W-1:0]  key_hash;
    logic [VAL_W-1:0]  new_value;

    modport source (output valid, output req_type, output key_hash, output new_value,
                    input ready);
    modport sink   (input valid, input req_type, input key_hash, input new_value,
                    output ready);
endinterface

[rtl/lpht_rsp_if.sv]
interface lpht_rsp_if;
    import lpht_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [VAL_W-1:0]  old_value;
    logic              changed;
    logic [1:0]        status;
    logic [LIVE_W-1:0] live_entries;

    modport source (output valid, output found, output old_value, output changed,
                    output status, output live_entries, input ready);
    modport sink   (input valid, input found, input old_value, input changed,
                    input status, input live_entries, output ready);
endinterface

[rtl/lpht_mem.sv]
module lpht_mem
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                     clk,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic [KEY_W-1:0]         rd_key,
    output logic                     rd_live,
    output logic [VAL_W-1:0]         rd_value,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  mem_wr_t                  wr
);
    // Key store carries the live bit alongside the key
    logic [KEY_W:0]   key_mem [SLOTS];
    logic [VAL_W-1:0] val_mem [SLOTS];
    logic [KEY_W:0]   key_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;

    // Key/live store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr_addr] <= {wr.live, wr.key};
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    // Value store: no reset, only read back from live buckets
    always_ff @(posedge clk)
    begin
        if (wr.val_we)
        begin
            val_mem[wr_addr] <= wr.value;
        end
        val_rd_reg <= val_mem[rd_addr];
    end

    assign rd_key   = key_rd_reg[KEY_W-1:0];
    assign rd_live  = key_rd_reg[KEY_W];
    assign rd_value = val_rd_reg;
endmodule

[rtl/lpht_ctrl.sv]
module lpht_ctrl
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    lpht_req_if.sink                 req,
    lpht_rsp_if.source               rsp,
    input  logic                     cfg_wr_en,
    input  logic [FILL_W-1:0]        cfg_wr_data,
    output logic [$clog2(SLOTS)-1:0] rd_addr,
    input  logic [KEY_W-1:0]         rd_key,
    input  logic                     rd_live,
    input  logic [VAL_W-1:0]         rd_value,
    output logic [$clog2(SLOTS)-1:0] wr_addr,
    output mem_wr_t                  wr
);
    localparam int IW    = $clog2(SLOTS);
    localparam int CNT_W = (IW + 1 > LIVE_W) ? IW + 1 : LIVE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [IW-1:0]        idx_reg, probe_cnt_reg, clr_cnt_reg;
    logic [CNT_W-1:0]     res_cnt_reg, live_cnt_reg;
    logic [CNT_W-1:0]     res_cnt_next, live_cnt_next;
    logic [FILL_W-1:0]    fill_reg;
    logic                 out_valid_reg;
    logic                 out_found_reg, out_changed_reg;
    logic [VAL_W-1:0]     out_old_reg;
    status_t              out_status_reg;
    logic [LIVE_W-1:0]    out_live_reg;

    logic                 accept, key_zero, match, empty, live, last, resolved;
    logic                 out_free, done, advance;
    logic                 res_found, res_changed, res_inc, live_inc, live_dec;
    logic                 key_we, val_we, new_live;
    status_t              res_status;
    op_t                  op_in;

    assign accept = req.valid && req.ready;
    assign op_in  = (req.req_type > 3'(OP_REMOVE)) ? OP_GET : op_t'(req.req_type);

    // Probe evaluation on the bucket just read
    assign key_zero = (key_reg == '0);
    assign match    = (rd_key == key_reg);
    assign empty    = (rd_key == '0);
    assign live     = match && rd_live;
    assign last     = (probe_cnt_reg == LAST_IDX);
    assign resolved = key_zero || match || empty || last;
    assign out_free = !out_valid_reg || rsp.ready;
    assign done     = (state_reg == S_CHECK) && resolved && out_free;
    assign advance  = (state_reg == S_CHECK) && !resolved;

    // Operation decision
    always_comb
    begin
        res_found   = 1'b0;
        res_changed = 1'b0;
        res_status  = ST_OK;
        res_inc     = 1'b0;
        live_inc    = 1'b0;
        live_dec    = 1'b0;
        key_we      = 1'b0;
        val_we      = 1'b0;
        new_live    = 1'b1;
        if (key_zero)
        begin
            res_status = ST_ZERO;
        end
        else
        begin
            res_found = live;
            case (op_reg)
                OP_PUT, OP_ADD:
                begin
                    if (live)
                    begin
                        if (op_reg == OP_PUT)
                        begin
                            val_we      = 1'b1;
                            res_changed = 1'b1;
                        end
                    end
                    else if (match)
                    begin
                        // revive a removed entry in place
                        key_we      = 1'b1;
                        val_we      = 1'b1;
                        live_inc    = 1'b1;
                        res_changed = 1'b1;
                    end
                    else if (!empty || res_cnt_reg >= CNT_W'(fill_reg))
                    begin
                        res_status = ST_FULL;
                    end
                    else
                    begin
                        key_we      = 1'b1;
                        val_we      = 1'b1;
                        res_inc     = 1'b1;
                        live_inc    = 1'b1;
                        res_changed = 1'b1;
                    end
                end
                OP_REPLACE:
                begin
                    if (live)
                    begin
                        val_we      = 1'b1;
                        res_changed = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (live)
                    begin
                        key_we      = 1'b1;
                        new_live    = 1'b0;
                        live_dec    = 1'b1;
                        res_changed = 1'b1;
                    end
                end
                default:
                begin
                    res_changed = 1'b0;
                end
            endcase
        end
    end

    assign res_cnt_next  = res_cnt_reg + CNT_W'(done && res_inc);
    assign live_cnt_next = live_cnt_reg + CNT_W'(done && live_inc)
                           - CNT_W'(done && live_dec);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // State outputs: handshake, memory addressing and writes
    always_comb
    begin
        req.ready = 1'b0;
        rd_addr   = idx_reg;
        wr_addr   = idx_reg;
        wr.key_we = 1'b0;
        wr.val_we = 1'b0;
        wr.live   = new_live;
        wr.key    = key_reg;
        wr.value  = val_reg;
        case (state_reg)
            S_CLEAR:
            begin
                wr_addr   = clr_cnt_reg;
                wr.key_we = 1'b1;
                wr.live   = 1'b0;
                wr.key    = '0;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                rd_addr   = req.key_hash[IW-1:0];
            end
            S_CHECK:
            begin
                if (advance)
                begin
                    rd_addr = idx_reg + 1'b1;
                end
                wr.key_we = done && key_we;
                wr.val_we = done && val_we;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            res_cnt_reg   <= '0;
            live_cnt_reg  <= '0;
            fill_reg      <= FILL_LIMIT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_cnt_reg  <= res_cnt_next;
            live_cnt_reg <= live_cnt_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_wr_en)
            begin
                fill_reg <= cfg_wr_data;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and probe payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= op_in;
            key_reg       <= req.key_hash;
            val_reg       <= req.new_value;
            idx_reg       <= req.key_hash[IW-1:0];
            probe_cnt_reg <= '0;
        end
        else if (advance)
        begin
            idx_reg       <= idx_reg + 1'b1;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
    end

    // Result beat register
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_found_reg   <= res_found;
            out_old_reg     <= res_found ? rd_value : '0;
            out_changed_reg <= res_changed;
            out_status_reg  <= res_status;
            out_live_reg    <= live_cnt_next[LIVE_W-1:0];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.old_value    = out_old_reg;
    assign rsp.changed      = out_changed_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.live_entries = out_live_reg;
endmodule

[rtl/linear_probe_hash_table_top.sv]
// Open-addressed hash table with linear probing over SLOTS buckets (a power of
// two). Each request beat carries an operation, a nonzero 64-bit key hash and a
// value; exactly one response beat comes back per request. After reset the block
// runs a clearing pass over all SLOTS buckets of the key store and takes no
// request until it finishes (fill_limit writes are taken throughout). A request
// then probes from 1 to SLOTS buckets: the key/value memories give one bucket
// per cycle through their single registered read port, and one request is in
// flight at a time. A finished response sits in an output register, so the next
// request is accepted while it waits.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    lpht_req_if.sink          req,
    lpht_rsp_if.source        rsp,
    input  logic              cfg_wr_en,
    input  logic [FILL_W-1:0] cfg_wr_data
);
    localparam int IW = $clog2(SLOTS);

    logic [IW-1:0]    rd_addr, wr_addr;
    logic [KEY_W-1:0] rd_key;
    logic             rd_live;
    logic [VAL_W-1:0] rd_value;
    mem_wr_t          wr;

    // Probe sequencer and counters
    lpht_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rd_addr     (rd_addr),
        .rd_key      (rd_key),
        .rd_live     (rd_live),
        .rd_value    (rd_value),
        .wr_addr     (wr_addr),
        .wr          (wr)
    );

    // Bucket storage
    lpht_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_live  (rd_live),
        .rd_value (rd_value),
        .wr_addr  (wr_addr),
        .wr       (wr)
    );
endmodule
